/* hdl/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, constants and helpers for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int unsigned MaxSlotsDef = 4096;
  localparam int unsigned WordBits    = 64;
  localparam int unsigned BitIdxW     = 6;
  localparam int unsigned CapW        = 13;
  localparam int unsigned SlotIdxW    = 12;
  localparam int unsigned CountW      = 13;
  localparam int unsigned AddrW       = 3;

  localparam logic [CapW-1:0]  CapReset    = 13'd4096;
  localparam logic [AddrW-1:0] AddrSlotCap = 3'd0;

  localparam logic       ReqAlloc = 1'b0;
  localparam logic       ReqFree  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [SlotIdxW-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SlotIdxW-1:0] granted_slot;
    logic [CountW-1:0]   used_count;
  } rsp_t;

  // full flag update for one word
  typedef struct packed {
    logic en;
    logic full;
  } flag_upd_t;

  // position of the lowest clear bit, zero when the word is all ones
  function automatic logic [BitIdxW-1:0] lowest_clear(input logic [WordBits-1:0] word);
    logic [BitIdxW-1:0] pos;
    pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BitIdxW'(i);
      end
    end
    return pos;
  endfunction

endpackage

/* hdl/bsa_occ_mem.sv */
// ----------------------------------------------------------------------------
// bsa_occ_mem
// Occupancy bitmap store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bsa_occ_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [bsa_pkg::WordBits-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [bsa_pkg::WordBits-1:0] rdata_o
);
  import bsa_pkg::*;

  logic [WordBits-1:0] mem_q [Depth];
  logic [WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bsa_word_scan.sv */
// ----------------------------------------------------------------------------
// bsa_word_scan
// Per-word full flags and the search for the first word with a free slot.
// ----------------------------------------------------------------------------
module bsa_word_scan #(
  parameter int unsigned WordCount = 64,
  parameter int unsigned AW        = 6,
  parameter int unsigned LimW      = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsa_pkg::flag_upd_t upd_i,
  input  logic [AW-1:0]      upd_word_i,
  input  logic [LimW-1:0]    word_limit_i,
  output logic [AW-1:0]      free_word_o,
  output logic               found_o
);
  import bsa_pkg::*;

  logic [WordCount-1:0] full_q, full_d;
  logic [AW-1:0]        first;
  logic                 any;

  always_comb begin
    full_d = full_q;
    if (upd_i.en) begin
      full_d[upd_word_i] = upd_i.full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else begin
      full_q <= full_d;
    end
  end

  always_comb begin
    first = '0;
    any   = 1'b0;
    for (int i = WordCount - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        first = AW'(i);
        any   = 1'b1;
      end
    end
  end

  // only words below the capacity limit take part
  assign free_word_o = first;
  assign found_o     = any && (LimW'(first) < word_limit_i);

endmodule

/* hdl/bitmap_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// First-fit slot allocator over an occupancy bitmap held in one memory.
// ----------------------------------------------------------------------------
// flow: a request is captured with its word pick on the transfer in, the occupancy
//   word is read in S_READ, and S_MOD writes the updated bit back and loads the output
//   register, waiting there while the output is stalled; no new request is taken
//   until this read-modify-write is through. reset: a clearing pass zeroes every word of
//   the bitmap with in_stall_o high; configuration writes are taken throughout
module bitmap_slot_allocator_unit #(
  parameter int unsigned MaxSlots = bsa_pkg::MaxSlotsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bsa_pkg::req_t             in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bsa_pkg::rsp_t             out_rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bsa_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bsa_pkg::*;

  localparam int unsigned WordCount = (MaxSlots + WordBits - 1) / WordBits;
  localparam int unsigned AW        = (WordCount > 1) ? $clog2(WordCount) : 1;
  localparam int unsigned SlotW     = AW + BitIdxW;
  localparam int unsigned CmpW      = ((SlotW > CapW) ? SlotW : CapW) + 1;
  localparam int unsigned CntW      = $clog2(MaxSlots + 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_MOD   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [CapW-1:0]     cap_q, cap_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                req_q;
  logic [SlotIdxW-1:0] idx_q;
  logic [AW-1:0]       addr_q;
  logic                none_q;
  logic                out_valid_q, out_valid_d;
  rsp_t                rsp_q, rsp_d;

  logic [CmpW-1:0]     cap_ext, cap_eff, word_limit, idx_ext, slot_ext, cnt_ext;
  logic [AW-1:0]       scan_word, idx_word;
  logic                scan_found;
  logic                accept, busy_out, finish;
  logic [WordBits-1:0] rdata, wdata, mask;
  logic [BitIdxW-1:0]  bit_pos;
  logic                alloc_ok, free_ok, op_ok;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr;
  flag_upd_t           upd;

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(cap_q);

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && (paddr == AddrSlotCap)) begin
      cap_d = pwdata[CapW-1:0];
    end
  end

  assign cap_ext    = CmpW'(cap_q);
  assign cap_eff    = (cap_ext > CmpW'(MaxSlots)) ? CmpW'(MaxSlots) : cap_ext;
  assign word_limit = (cap_eff + CmpW'(WordBits - 1)) >> BitIdxW;
  assign idx_ext    = CmpW'(in_req_i.slot_index);
  assign idx_word   = idx_ext[SlotW-1:BitIdxW];

  bsa_word_scan #(
    .WordCount (WordCount),
    .AW        (AW),
    .LimW      (CmpW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .upd_i        (upd),
    .upd_word_i   (addr_q),
    .word_limit_i (word_limit),
    .free_word_o  (scan_word),
    .found_o      (scan_found)
  );

  bsa_occ_mem #(
    .Depth (WordCount),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign accept   = (state_q == S_IDLE) && in_valid_i;
  assign busy_out = out_valid_q && out_stall_i;
  assign finish   = (state_q == S_MOD) && !busy_out;

  // modify stage
  assign bit_pos  = lowest_clear(rdata);
  assign slot_ext = CmpW'({addr_q, bit_pos});
  assign alloc_ok = (req_q == ReqAlloc) && !none_q && (slot_ext < cap_eff);
  assign free_ok  = (req_q == ReqFree) && !none_q && rdata[idx_q[BitIdxW-1:0]];
  assign op_ok    = alloc_ok || free_ok;
  assign mask     = (req_q == ReqAlloc) ? (WordBits'(1) << bit_pos)
                                        : (WordBits'(1) << idx_q[BitIdxW-1:0]);

  always_comb begin
    if (state_q == S_CLEAR) begin
      wdata = '0;
    end else if (req_q == ReqAlloc) begin
      wdata = rdata | mask;
    end else begin
      wdata = rdata & ~mask;
    end
  end

  assign mem_we    = (state_q == S_CLEAR) || (finish && op_ok);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
  assign mem_re    = (state_q == S_READ);

  assign upd.en   = finish && op_ok;
  assign upd.full = alloc_ok && (&wdata);

  always_comb begin
    cnt_d = cnt_q;
    if (finish && alloc_ok) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (finish && free_ok && (cnt_q != '0)) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  assign cnt_ext = CmpW'(cnt_d);

  always_comb begin
    rsp_d              = rsp_q;
    rsp_d.used_count   = cnt_ext[CountW-1:0];
    rsp_d.granted_slot = alloc_ok ? slot_ext[SlotIdxW-1:0] : '0;
    if (op_ok) begin
      rsp_d.status = StOk;
    end else if (req_q == ReqAlloc) begin
      rsp_d.status = StFull;
    end else begin
      rsp_d.status = StInvalid;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = AW'(clr_q + 1'b1);
        if (clr_q == AW'(WordCount - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_MOD;
      end
      S_MOD: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cap_q       <= CapReset;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cap_q       <= cap_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture and word pick on the input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i.req_type;
      idx_q <= in_req_i.slot_index;
      if (in_req_i.req_type == ReqAlloc) begin
        addr_q <= scan_word;
        none_q <= !scan_found;
      end else begin
        addr_q <= idx_word;
        none_q <= (idx_ext >= cap_eff);
      end
    end
    if (finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
